>>> sv/dtpq_pkg.sv
package dtpq_pkg;

    // Store geometry and field widths.
    localparam int DEPTH_DEFAULT = 32;
    localparam int ID_W          = 16;
    localparam int SIZE_W        = 16;
    localparam int DESC_W        = ID_W + SIZE_W;
    localparam int LIMIT_W       = 6;
    localparam int MEAN_W        = 16;
    localparam int BYTE_W        = 21;
    localparam int LIMB_W        = LIMIT_W + MEAN_W;
    localparam int CMP_W         = 7;

    // Configuration register file.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_PACKET_LIMIT = 2'd0,
        REG_MEAN_SIZE    = 2'd1,
        REG_COUNT_BYTES  = 2'd2,
        REG_DROP_FRONT   = 2'd3
    } t_reg;

    localparam logic [LIMIT_W-1:0] PACKET_LIMIT_RST = 6'd33;
    localparam logic [MEAN_W-1:0]  MEAN_SIZE_RST    = 16'd1000;

    // Operation selector carried on the input tuser.
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SHRINK  = 2'd2
    } t_op;

    // Result kind carried on the output tuser.
    typedef enum logic [2:0] {
        EV_ACCEPT = 3'd0,
        EV_DROP   = 3'd1,
        EV_DEQ    = 3'd2,
        EV_EMPTY  = 3'd3,
        EV_DONE   = 3'd4
    } t_event;

endpackage

>>> sv/dtpq_ram.sv
module dtpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/drop_tail_packet_queue.sv
// A word is taken in S_IDLE, where a defined operation starts the descriptor RAM read, and its result
// is registered in S_EXEC from that registered read once the output register is free; no new word is taken before then.
// Shrink stays in S_EXEC, with one RAM read and one drop per cycle while the output register is free.
// A result waits in the output register while the next word is taken.
// Reset is synchronous and active low; it clears pointers and counts and loads the configuration reset values.
// The descriptor RAM is not cleared, since an entry is always written before its read data is used.
module drop_tail_packet_queue #(
    parameter int DEPTH = dtpq_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input words.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [31:0]                     i_s_tdata,  // packet_id[15:0], packet_size[31:16]
    input  logic [1:0]                      i_s_tuser,  // operation[1:0]
    // Result words.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,  // out_packet_id[15:0], out_packet_size[31:16]
    output logic [2:0]                      o_m_tuser,  // event_res[2:0]
    output logic                            o_m_tlast,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dtpq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dtpq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dtpq_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Configuration registers.
    logic [dtpq_pkg::LIMIT_W-1:0] r_pkt_limit;
    logic [dtpq_pkg::MEAN_W-1:0]  r_mean;
    logic                         r_in_bytes;
    logic                         r_dff;
    logic [dtpq_pkg::LIMB_W-1:0]  r_limit_bytes;

    // Queue state and the word in progress.
    t_state                      r_state, n_state;
    logic [PTR_W-1:0]            r_head, n_head;
    logic [PTR_W-1:0]            r_tail, n_tail;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [dtpq_pkg::BYTE_W-1:0] r_bytes, n_bytes;
    dtpq_pkg::t_op               r_op, n_op;
    logic [dtpq_pkg::ID_W-1:0]   r_pid, n_pid;
    logic [dtpq_pkg::SIZE_W-1:0] r_psz, n_psz;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    dtpq_pkg::t_event            r_ev, n_ev;
    logic [dtpq_pkg::ID_W-1:0]   r_oid, n_oid;
    logic [dtpq_pkg::SIZE_W-1:0] r_osz, n_osz;
    logic                        r_olast, n_olast;

    // Descriptor RAM port signals.
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_waddr;
    logic [dtpq_pkg::DESC_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [PTR_W-1:0]            ram_raddr;
    logic [dtpq_pkg::DESC_W-1:0] ram_rdata;
    logic [dtpq_pkg::ID_W-1:0]   rd_id;
    logic [dtpq_pkg::SIZE_W-1:0] rd_size;

    logic                        cfg_wr;
    dtpq_pkg::t_reg              cfg_idx;
    dtpq_pkg::t_op               in_op;
    logic                        in_op_valid;
    logic                        out_free;
    logic                        over;
    logic                        shrink_more;
    logic [dtpq_pkg::LIMB_W-1:0] bytes_sum;
    logic [dtpq_pkg::CMP_W-1:0]  count_ext;
    logic [dtpq_pkg::CMP_W-1:0]  limit_ext;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    dtpq_ram #(
        .WIDTH (dtpq_pkg::DESC_W),
        .DEPTH (DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id   = ram_rdata[dtpq_pkg::ID_W-1:0];
    assign rd_size = ram_rdata[dtpq_pkg::DESC_W-1:dtpq_pkg::ID_W];

    // Register file: writes complete in the access phase, pready is tied high.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = dtpq_pkg::t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_limit <= dtpq_pkg::PACKET_LIMIT_RST;
            r_mean      <= dtpq_pkg::MEAN_SIZE_RST;
            r_in_bytes  <= 1'b0;
            r_dff       <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dtpq_pkg::REG_PACKET_LIMIT: r_pkt_limit <= pwdata[dtpq_pkg::LIMIT_W-1:0];
                dtpq_pkg::REG_MEAN_SIZE:    r_mean      <= pwdata[dtpq_pkg::MEAN_W-1:0];
                dtpq_pkg::REG_COUNT_BYTES:  r_in_bytes  <= pwdata[0];
                dtpq_pkg::REG_DROP_FRONT:   r_dff       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // The byte limit is recomputed every cycle into a register, so it trails a configuration write.
    always_ff @(posedge i_clk) begin
        r_limit_bytes <= dtpq_pkg::LIMB_W'(r_pkt_limit * r_mean);
    end

    always_comb begin
        case (dtpq_pkg::t_reg'(paddr[3:2]))
            dtpq_pkg::REG_PACKET_LIMIT: prdata = dtpq_pkg::APB_DATA_W'(r_pkt_limit);
            dtpq_pkg::REG_MEAN_SIZE:    prdata = dtpq_pkg::APB_DATA_W'(r_mean);
            dtpq_pkg::REG_COUNT_BYTES:  prdata = dtpq_pkg::APB_DATA_W'(r_in_bytes);
            dtpq_pkg::REG_DROP_FRONT:   prdata = dtpq_pkg::APB_DATA_W'(r_dff);
            default:                    prdata = '0;
        endcase
    end

    // Limit checks for the word in progress.
    assign count_ext   = dtpq_pkg::CMP_W'(r_count);
    assign limit_ext   = dtpq_pkg::CMP_W'(r_pkt_limit);
    assign bytes_sum   = dtpq_pkg::LIMB_W'(r_bytes) + dtpq_pkg::LIMB_W'(r_psz);
    assign over        = (r_count >= FULL_CNT) ||
                         (r_in_bytes ? (bytes_sum >= r_limit_bytes)
                                     : ((count_ext + dtpq_pkg::CMP_W'(1)) >= limit_ext));
    assign shrink_more = (r_count != '0) &&
                         (r_in_bytes ? (dtpq_pkg::LIMB_W'(r_bytes) > r_limit_bytes)
                                     : (count_ext > limit_ext));

    assign in_op       = dtpq_pkg::t_op'(i_s_tuser);
    assign in_op_valid = (in_op == dtpq_pkg::OP_ENQUEUE) || (in_op == dtpq_pkg::OP_DEQUEUE) ||
                         (in_op == dtpq_pkg::OP_SHRINK);
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);

    // Sequencer: read the head or last entry on accept, then update the queue; only enqueue writes.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_op        = r_op;
        n_pid       = r_pid;
        n_psz       = r_psz;
        n_out_valid = r_out_valid && !i_m_tready;
        n_ev        = r_ev;
        n_oid       = r_oid;
        n_osz       = r_osz;
        n_olast     = r_olast;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        ram_wdata   = {r_psz, r_pid};
        ram_re      = 1'b0;
        ram_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op  = in_op;
                    n_pid = i_s_tdata[15:0];
                    n_psz = i_s_tdata[31:16];
                    if (in_op_valid) begin
                        ram_re  = 1'b1;
                        n_state = S_EXEC;
                        if (in_op == dtpq_pkg::OP_SHRINK && !r_dff) begin
                            ram_raddr = ptr_prev(r_tail);
                        end
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_olast     = 1'b1;
                    n_oid       = '0;
                    n_osz       = '0;
                    n_state     = S_IDLE;
                    case (r_op)
                        dtpq_pkg::OP_ENQUEUE: begin
                            n_ev = dtpq_pkg::EV_DROP;
                            if (!over) begin
                                n_ev    = dtpq_pkg::EV_ACCEPT;
                                ram_we  = 1'b1;
                                n_tail  = ptr_next(r_tail);
                                n_count = r_count + CNT_W'(1);
                                n_bytes = r_bytes + dtpq_pkg::BYTE_W'(r_psz);
                            end else if (r_dff && r_count != '0) begin
                                // Replace the head: the new packet goes in, the head goes out.
                                n_oid   = rd_id;
                                n_osz   = rd_size;
                                ram_we  = 1'b1;
                                n_head  = ptr_next(r_head);
                                n_tail  = ptr_next(r_tail);
                                n_bytes = r_bytes + dtpq_pkg::BYTE_W'(r_psz)
                                          - dtpq_pkg::BYTE_W'(rd_size);
                            end else begin
                                n_oid = r_pid;
                                n_osz = r_psz;
                            end
                        end
                        dtpq_pkg::OP_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_ev = dtpq_pkg::EV_EMPTY;
                            end else begin
                                n_ev    = dtpq_pkg::EV_DEQ;
                                n_oid   = rd_id;
                                n_osz   = rd_size;
                                n_head  = ptr_next(r_head);
                                n_count = r_count - CNT_W'(1);
                                n_bytes = r_bytes - dtpq_pkg::BYTE_W'(rd_size);
                            end
                        end
                        dtpq_pkg::OP_SHRINK: begin
                            if (shrink_more) begin
                                // Drop one packet and fetch the next candidate.
                                n_ev    = dtpq_pkg::EV_DROP;
                                n_oid   = rd_id;
                                n_osz   = rd_size;
                                n_olast = 1'b0;
                                n_count = r_count - CNT_W'(1);
                                n_bytes = r_bytes - dtpq_pkg::BYTE_W'(rd_size);
                                n_state = S_EXEC;
                                ram_re  = 1'b1;
                                if (r_dff) begin
                                    n_head    = ptr_next(r_head);
                                    ram_raddr = ptr_next(r_head);
                                end else begin
                                    n_tail    = ptr_prev(r_tail);
                                    ram_raddr = ptr_prev(ptr_prev(r_tail));
                                end
                            end else begin
                                n_ev = dtpq_pkg::EV_DONE;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_m_tready;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
        r_op    <= n_op;
        r_pid   <= n_pid;
        r_psz   <= n_psz;
        r_ev    <= n_ev;
        r_oid   <= n_oid;
        r_osz   <= n_osz;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_osz, r_oid};
    assign o_m_tuser  = r_ev;
    assign o_m_tlast  = r_olast;

    // The queue never holds more packets than the store has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("packet count exceeds store depth");

    // An empty queue has its pointers together and no bytes left over.
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_head == r_tail) && (r_bytes == '0)))
        else $error("empty queue with stale pointers or byte count");

    // A full queue also has its pointers together.
    a_full_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FULL_CNT) |-> (r_head == r_tail))
        else $error("full queue with pointers apart");

    // A taken word with a defined operation blocks further input for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && in_op_valid) |=> !o_s_tready)
        else $error("input taken while a word is still in progress");

endmodule

>>> tb/tb_drop_tail_packet_queue.sv
module tb_drop_tail_packet_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH         = dtpq_pkg::DEPTH_DEFAULT;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          SETTLE_CYCLES = DEPTH + 8;
    localparam int          LONG_STALL    = 300;
    localparam int          CYCLE_LIMIT   = 1000000;

    // One input word as the sender offers it.
    typedef struct {
        logic [1:0]  op;
        logic [15:0] id;
        logic [15:0] size;
        bit          drain_first;
    } t_pkt_cmd;

    // One result word as the block should deliver it.
    typedef struct {
        dtpq_pkg::t_event ev;
        logic [15:0]      id;
        logic [15:0]      size;
        logic             last;
    } t_pkt_event;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;  // packet_id[15:0], packet_size[31:16]
    logic [1:0]  i_s_tuser  = '0;  // operation[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // out_packet_id[15:0], out_packet_size[31:16]
    logic [2:0]  o_m_tuser;        // event_res[2:0]
    logic        o_m_tlast;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [dtpq_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [dtpq_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [dtpq_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    drop_tail_packet_queue #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [5:0]  cfg_limit = dtpq_pkg::PACKET_LIMIT_RST;
    logic [15:0] cfg_mean  = dtpq_pkg::MEAN_SIZE_RST;
    bit          cfg_bytes = 1'b0;
    bit          cfg_front = 1'b0;

    // Shadow copy of the descriptor queue.
    logic [15:0] sh_id   [DEPTH];
    logic [15:0] sh_size [DEPTH];
    int          sh_head  = 0;
    int          sh_tail  = 0;
    int          sh_count = 0;
    logic [20:0] sh_bytes = '0;

    t_pkt_cmd   stim_words[$];
    t_pkt_event due_events[$];
    t_pkt_cmd   on_bus;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int stalls_asked = 0;
    int stalls_done  = 0;
    int stall_left   = 0;
    int cycle_count  = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int drops_seen   = 0;
    int reg_writes   = 0;
    int mismatches   = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void add_event(input dtpq_pkg::t_event ev, input logic [15:0] id,
                                      input logic [15:0] sz, input logic last);
        due_events.push_back('{ev, id, sz, last});
    endfunction

    function automatic void put_tail(input logic [15:0] id, input logic [15:0] sz);
        sh_id[sh_tail]   = id;
        sh_size[sh_tail] = sz;
        sh_tail  = (sh_tail + 1) % DEPTH;
        sh_count = sh_count + 1;
        sh_bytes = sh_bytes + 21'(sz);
    endfunction

    function automatic void take_head(output logic [15:0] id, output logic [15:0] sz);
        id = sh_id[sh_head];
        sz = sh_size[sh_head];
        sh_head  = (sh_head + 1) % DEPTH;
        sh_count = sh_count - 1;
        sh_bytes = sh_bytes - 21'(sz);
    endfunction

    // Advance the shadow queue by one accepted word and queue the results it causes.
    function automatic void step_shadow_queue(input t_pkt_cmd w);
        logic [31:0] byte_cap;
        logic [15:0] rid;
        logic [15:0] rsz;
        bit          over;
        int          k;
        byte_cap = 32'(cfg_limit) * 32'(cfg_mean);
        k = 0;
        case (w.op)
            dtpq_pkg::OP_ENQUEUE: begin
                if (cfg_bytes)
                    over = (32'(sh_bytes) + 32'(w.size)) >= byte_cap;
                else
                    over = (sh_count + 1) >= int'(cfg_limit);
                if (sh_count >= DEPTH)
                    over = 1'b1;
                if (!over) begin
                    put_tail(w.id, w.size);
                    add_event(dtpq_pkg::EV_ACCEPT, '0, '0, 1'b1);
                end else if (cfg_front && sh_count > 0) begin
                    take_head(rid, rsz);
                    put_tail(w.id, w.size);
                    add_event(dtpq_pkg::EV_DROP, rid, rsz, 1'b1);
                end else begin
                    add_event(dtpq_pkg::EV_DROP, w.id, w.size, 1'b1);
                end
            end
            dtpq_pkg::OP_DEQUEUE: begin
                if (sh_count == 0) begin
                    add_event(dtpq_pkg::EV_EMPTY, '0, '0, 1'b1);
                end else begin
                    take_head(rid, rsz);
                    add_event(dtpq_pkg::EV_DEQ, rid, rsz, 1'b1);
                end
            end
            dtpq_pkg::OP_SHRINK: begin
                // Drop until the queue fits, from the head or the tail.
                while (sh_count > 0 && k < DEPTH &&
                       (cfg_bytes ? (32'(sh_bytes) > byte_cap)
                                  : (sh_count > int'(cfg_limit)))) begin
                    if (cfg_front) begin
                        take_head(rid, rsz);
                    end else begin
                        sh_tail  = (sh_tail + DEPTH - 1) % DEPTH;
                        rid      = sh_id[sh_tail];
                        rsz      = sh_size[sh_tail];
                        sh_count = sh_count - 1;
                        sh_bytes = sh_bytes - 21'(rsz);
                    end
                    add_event(dtpq_pkg::EV_DROP, rid, rsz, 1'b0);
                    k++;
                end
                add_event(dtpq_pkg::EV_DONE, '0, '0, 1'b1);
            end
            default: begin
                // The unused operation code is swallowed without a result.
            end
        endcase
    endfunction

    // Sender: takes words from the pending queue and holds each until it is taken.
    always @(posedge i_clk) begin : feed_words
        bit go;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                step_shadow_queue(on_bus);
                words_sent++;
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                go = stim_words.size() != 0 && $urandom_range(99) >= tx_idle_pct;
                if (go && stim_words[0].drain_first && due_events.size() != 0)
                    go = 1'b0;
                if (go) begin
                    on_bus = stim_words.pop_front();
                    i_s_tdata <= {on_bus.size, on_bus.id};
                    i_s_tuser <= on_bus.op;
                end
                i_s_tvalid <= go;
            end
        end
    end

    // Long receiver hold-off, armed by the stimulus process.
    always @(posedge i_clk) begin : hold_off
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stalls_done != stalls_asked) begin
            stall_left  <= LONG_STALL;
            stalls_done <= stalls_done + 1;
        end
    end

    // Receiver: checks each taken result word against the oldest one due.
    always @(posedge i_clk) begin : watch_results
        t_pkt_event want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (due_events.size() == 0) begin
                report_mismatch("result word with none due", o_m_tdata, '0);
            end else begin
                want = due_events.pop_front();
                if (want.ev == dtpq_pkg::EV_DROP)
                    drops_seen++;
                if (o_m_tuser !== want.ev)
                    report_mismatch("event_res", 32'(o_m_tuser), 32'(want.ev));
                if (o_m_tdata[15:0] !== want.id)
                    report_mismatch("out_packet_id", 32'(o_m_tdata[15:0]), 32'(want.id));
                if (o_m_tdata[31:16] !== want.size)
                    report_mismatch("out_packet_size", 32'(o_m_tdata[31:16]),
                                    32'(want.size));
                if (o_m_tlast !== want.last)
                    report_mismatch("tlast", 32'(o_m_tlast), 32'(want.last));
            end
        end
        if (stall_left != 0)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles with %0d results due.",
                     cycle_count, due_events.size());
            $display("status: fail");
            $finish;
        end
    end

    // Register write over the configuration port; the block must be idle.
    task automatic set_reg(input dtpq_pkg::t_reg r, input logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dtpq_pkg::APB_ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            dtpq_pkg::REG_PACKET_LIMIT: cfg_limit = v[5:0];
            dtpq_pkg::REG_MEAN_SIZE:    cfg_mean  = v[15:0];
            dtpq_pkg::REG_COUNT_BYTES:  cfg_bytes = v[0];
            dtpq_pkg::REG_DROP_FRONT:   cfg_front = v[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    // Wait until every word is taken and every result has come, then let the block settle.
    task automatic settle_block();
        do @(negedge i_clk);
        while (stim_words.size() != 0 || i_s_tvalid || due_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic void add_word(input logic [1:0] op, input logic [15:0] id,
                                     input logic [15:0] sz);
        stim_words.push_back('{op, id, sz, 1'b0});
    endfunction

    function automatic t_pkt_cmd rand_cmd(input int enq_pct, input bit small_sizes,
                                          input bit drain);
        t_pkt_cmd c;
        int       pick;
        pick   = $urandom_range(99);
        c.op   = (pick < enq_pct) ? dtpq_pkg::OP_ENQUEUE :
                 (pick < 95)      ? dtpq_pkg::OP_DEQUEUE :
                 (pick < 98)      ? dtpq_pkg::OP_SHRINK  : OP_UNUSED;
        c.id   = 16'($urandom);
        case ($urandom_range(7))
            0:       c.size = 16'h0000;
            1:       c.size = 16'hFFFF;
            default: c.size = small_sizes ? 16'($urandom_range(2000)) : 16'($urandom);
        endcase
        c.drain_first = drain || ($urandom_range(19) == 0);
        return c;
    endfunction

    // One random phase: a shrink to the new limit, then a burst of random words.
    task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                             input int enq_pct, input bit small_sizes, input bit long_hold);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (long_hold)
            stalls_asked++;
        stim_words.push_back('{dtpq_pkg::OP_SHRINK, 16'h0, 16'h0, 1'b1});
        for (int i = 0; i < n; i++)
            stim_words.push_back(rand_cmd(enq_pct, small_sizes, i == n / 2));
        settle_block();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: field extremes, every operation, empty dequeue and shrink.
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h0000, 16'h0000);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'hFFFF, 16'hFFFF);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h1234, 16'h8001);
        add_word(dtpq_pkg::OP_DEQUEUE, 16'hFFFF, 16'hFFFF);
        add_word(dtpq_pkg::OP_DEQUEUE, 16'h0000, 16'h0000);
        add_word(dtpq_pkg::OP_DEQUEUE, 16'h0000, 16'h0000);
        add_word(dtpq_pkg::OP_DEQUEUE, 16'h0000, 16'h0000);
        add_word(OP_UNUSED,            16'hFFFF, 16'hFFFF);
        add_word(dtpq_pkg::OP_SHRINK,  16'h0000, 16'h0000);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'hA5A5, 16'h5A5A);
        settle_block();

        // Small packet limit: the second arrival overflows and is dropped.
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd3);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h0001, 16'h0010);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h0002, 16'h0020);
        settle_block();

        // Drop-from-front: the head goes and the arrival is kept.
        set_reg(dtpq_pkg::REG_DROP_FRONT, 32'd1);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h0003, 16'h0030);
        settle_block();

        // Lowered limit, shrink from the head.
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd1);
        add_word(dtpq_pkg::OP_SHRINK, 16'h0000, 16'h0000);
        settle_block();

        // Limit zero: shrink from the tail empties the queue, every arrival is dropped.
        set_reg(dtpq_pkg::REG_DROP_FRONT, 32'd0);
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd0);
        add_word(dtpq_pkg::OP_SHRINK,  16'h0000, 16'h0000);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h7E57, 16'h0001);
        settle_block();

        // Byte mode with a zero mean size: the byte limit is zero.
        set_reg(dtpq_pkg::REG_COUNT_BYTES, 32'd1);
        set_reg(dtpq_pkg::REG_MEAN_SIZE, 32'd0);
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd33);
        add_word(dtpq_pkg::OP_ENQUEUE, 16'h0BAD, 16'h0000);
        settle_block();

        // Packet mode at full limit, no idling, one long receiver hold-off to fill the block.
        set_reg(dtpq_pkg::REG_COUNT_BYTES, 32'd0);
        set_reg(dtpq_pkg::REG_MEAN_SIZE, 32'd1000);
        run_phase(22, 0, 0, 80, 1'b0, 1'b1);

        // Low packet limit with drop-from-front; sender mostly idle.
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'($urandom_range(2, 8)));
        set_reg(dtpq_pkg::REG_DROP_FRONT, 32'd1);
        run_phase(22, 84, 0, 60, 1'b0, 1'b0);

        // Byte mode with the largest mean size, drop-from-front; receiver mostly stalled.
        set_reg(dtpq_pkg::REG_COUNT_BYTES, 32'd1);
        set_reg(dtpq_pkg::REG_MEAN_SIZE, 32'd65535);
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd33);
        run_phase(22, 0, 84, 85, 1'b0, 1'b0);

        // Small byte limit, drops from the tail; both sides idle now and then.
        set_reg(dtpq_pkg::REG_DROP_FRONT, 32'd0);
        set_reg(dtpq_pkg::REG_MEAN_SIZE, 32'($urandom_range(500, 1500)));
        set_reg(dtpq_pkg::REG_PACKET_LIMIT, 32'd10);
        run_phase(22, 24, 24, 65, 1'b1, 1'b0);

        $display("Sent %0d words and checked %0d results (%0d drops) over %0d register writes.",
                 words_sent, results_seen, drops_seen, reg_writes);
        $display("Covered packet and byte limits, zero limits, drop-from-front,");
        $display("shrink from both ends, the unused code, and idle, stall and hold-off patterns.");
        if (mismatches == 0 && due_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results still due.", mismatches, due_events.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
